### hw/rtl/lsi_pkg.sv
`timescale 1ns / 1ps

package lsi_pkg;

    localparam int LINE_OFFSET_W = 48;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [1:0] ENC_BYTES = 2'd0;
    localparam logic [1:0] ENC_LE    = 2'd1;
    localparam logic [1:0] ENC_BE    = 2'd2;
    localparam logic [1:0] ENC_UTF8  = 2'd3;

    localparam logic [1:0] KIND_FIRST = 2'd0;
    localparam logic [1:0] KIND_BREAK = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [15:0] CH_CR = 16'h000d;
    localparam logic [15:0] CH_LF = 16'h000a;

    localparam logic [7:0] BOM_FF = 8'hff;
    localparam logic [7:0] BOM_FE = 8'hfe;
    localparam logic [7:0] BOM_EF = 8'hef;
    localparam logic [7:0] BOM_BB = 8'hbb;
    localparam logic [7:0] BOM_BF = 8'hbf;

    // register index is paddr[2]
    localparam logic REG_DEFAULT_ENC = 1'b0;

    typedef struct packed {
        logic [LINE_OFFSET_W-1:0] line_offset;
        logic [1:0]               offset_kind;
        logic [1:0]               encoding_used;
        logic                     last_of_run;
    } res_t;

endpackage

### hw/rtl/line_start_indexer.sv
`timescale 1ns / 1ps
// The results of an item go into the registered result queue when the item is accepted.
// Throughput: one item per cycle while m_ready is high and each item yields at most one
// result; an item that yields two or three results (mark check, end of file) queues them
// all, and s_ready drops while the 4-entry result queue holds two or more.
// Reset (aresetn low at a clock edge) empties the queue, clears the scan state and
// sets default_encoding to 0.

module line_start_indexer
    import lsi_pkg::*;
#(
    parameter int OFFSET_BITS = 48
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_data_byte,
    input  logic                     s_end_marker,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [LINE_OFFSET_W-1:0] m_line_offset,
    output logic [1:0]               m_offset_kind,
    output logic [1:0]               m_encoding_used,
    output logic                     m_last_of_run,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    typedef struct packed {
        logic                   emit;
        logic [OFFSET_BITS-1:0] ofs;
        logic [15:0]            prev;
        logic                   phase;
        logic [7:0]             pend;
    } feed_t;

    // One byte into the character decoder and break detector.
    function automatic feed_t feed_f(
        input logic [1:0]             enc,
        input logic [15:0]            prev,
        input logic                   phase,
        input logic [7:0]             pend,
        input logic [7:0]             b,
        input logic [OFFSET_BITS-1:0] pos
    );
        feed_t                  r;
        logic [15:0]            c;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS:0]   sum;
        logic                   wide;
        logic                   take;
        r.emit  = 1'b0;
        r.ofs   = pos;
        r.prev  = prev;
        r.phase = phase;
        r.pend  = pend;
        wide    = (enc == ENC_LE) || (enc == ENC_BE);
        take    = 1'b1;
        c       = {8'h00, b};
        start   = pos;
        if (wide) begin
            if (!phase) begin
                take    = 1'b0;
                r.pend  = b;
                r.phase = 1'b1;
            end else begin
                r.phase = 1'b0;
                c       = (enc == ENC_LE) ? {b, pend} : {pend, b};
                start   = (pos == '0) ? '0 : pos - OFFSET_BITS'(1);
            end
        end
        sum = {1'b0, start} + (wide ? (OFFSET_BITS+1)'(2) : (OFFSET_BITS+1)'(1));
        if (take) begin
            if (prev == CH_CR || prev == CH_LF) begin
                r.emit = 1'b1;
                if (c == ((prev == CH_CR) ? CH_LF : CH_CR)) begin
                    c     = '0;
                    r.ofs = sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
                end else begin
                    r.ofs = start;
                end
            end
            r.prev = c;
        end
        return r;
    endfunction

    // scan state
    logic [1:0]             default_enc_reg, default_enc_next;
    logic [OFFSET_BITS-1:0] byte_count_reg, byte_count_next;
    logic [15:0]            prev_char_reg, prev_char_next;
    logic [7:0]             held_reg [2];
    logic [7:0]             held_next [2];
    logic [1:0]             held_count_reg, held_count_next;
    logic                   mark_checked_reg, mark_checked_next;
    logic [1:0]             active_enc_reg, active_enc_next;
    logic [7:0]             pend_reg, pend_next;
    logic                   phase_reg, phase_next;

    // result queue, head at entry 0
    res_t                   q_reg [QUEUE_DEPTH];
    res_t                   q_next [QUEUE_DEPTH];
    logic [2:0]             count_reg, count_next;

    logic                   s_fire;
    logic                   pop;
    logic                   cfg_wr;
    logic [1:0]             def_enc;
    logic [1:0]             mark_enc;
    logic                   skip0;
    logic                   mark_wide;
    logic [OFFSET_BITS-1:0] byte_count_inc;
    feed_t                  f0, f1, f2, fm, fn;
    res_t                   cand [3];
    logic [2:0]             cv;
    res_t                   pk [3];
    logic [1:0]             npush;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_DEFAULT_ENC);
    assign prdata  = (paddr[2] == REG_DEFAULT_ENC) ? {30'd0, default_enc_reg} : 32'd0;

    assign s_ready = (count_reg <= 3'd1);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (count_reg != 3'd0);
    assign pop     = m_valid && m_ready;

    assign m_line_offset   = q_reg[0].line_offset;
    assign m_offset_kind   = q_reg[0].offset_kind;
    assign m_encoding_used = q_reg[0].encoding_used;
    assign m_last_of_run   = q_reg[0].last_of_run;

    assign def_enc = (default_enc_reg == ENC_UTF8) ? ENC_BYTES : default_enc_reg;
    assign byte_count_inc = (&byte_count_reg) ? byte_count_reg
                                              : byte_count_reg + OFFSET_BITS'(1);

    // mark check on the two held bytes and the arriving third
    always_comb begin
        mark_enc = def_enc;
        if (held_reg[0] == BOM_FF && held_reg[1] == BOM_FE) begin
            mark_enc = ENC_LE;
        end else if (held_reg[0] == BOM_FE && held_reg[1] == BOM_FF) begin
            mark_enc = ENC_BE;
        end else if (held_reg[0] == BOM_EF && held_reg[1] == BOM_BB &&
                     s_data_byte == BOM_BF) begin
            mark_enc = ENC_UTF8;
        end
    end

    assign mark_wide = (held_reg[0] == BOM_FF && held_reg[1] == BOM_FE) ||
                       (held_reg[0] == BOM_FE && held_reg[1] == BOM_FF);
    assign skip0     = !mark_wide && (mark_enc != ENC_UTF8);

    // held bytes replayed under the default encoding
    assign f0 = feed_f(def_enc, 16'h0000, 1'b0, pend_reg, held_reg[0], '0);
    assign f1 = feed_f(def_enc, f0.prev, f0.phase, f0.pend, held_reg[1], OFFSET_BITS'(1));
    assign f2 = feed_f(def_enc, f1.prev, f1.phase, f1.pend, s_data_byte, OFFSET_BITS'(2));
    // third byte right after a two-byte mark
    assign fm = feed_f(mark_enc, 16'h0000, 1'b0, pend_reg, s_data_byte, OFFSET_BITS'(2));
    assign fn = feed_f(active_enc_reg, prev_char_reg, phase_reg, pend_reg, s_data_byte,
                       byte_count_reg);

    always_comb begin
        default_enc_next  = default_enc_reg;
        byte_count_next   = byte_count_reg;
        prev_char_next    = prev_char_reg;
        held_next         = held_reg;
        held_count_next   = held_count_reg;
        mark_checked_next = mark_checked_reg;
        active_enc_next   = active_enc_reg;
        pend_next         = pend_reg;
        phase_next        = phase_reg;
        cv                = 3'b000;
        for (int k = 0; k < 3; k++) begin
            cand[k] = '0;
        end

        if (cfg_wr) begin
            default_enc_next = pwdata[1:0];
        end

        if (s_fire) begin
            if (s_end_marker) begin
                cand[0] = '{line_offset: '0, offset_kind: KIND_FIRST,
                            encoding_used: def_enc, last_of_run: 1'b0};
                cv[0]   = !mark_checked_reg;
                cand[1] = '{line_offset: LINE_OFFSET_W'(f1.ofs), offset_kind: KIND_BREAK,
                            encoding_used: def_enc, last_of_run: 1'b0};
                cv[1]   = !mark_checked_reg && (held_count_reg == 2'd2) && f1.emit;
                cand[2] = '{line_offset: LINE_OFFSET_W'(byte_count_reg),
                            offset_kind: KIND_END,
                            encoding_used: mark_checked_reg ? active_enc_reg : def_enc,
                            last_of_run: 1'b0};
                cv[2]   = 1'b1;
                byte_count_next   = '0;
                prev_char_next    = '0;
                held_count_next   = '0;
                mark_checked_next = 1'b0;
                active_enc_next   = ENC_BYTES;
                pend_next         = '0;
                phase_next        = 1'b0;
            end else begin
                byte_count_next = byte_count_inc;
                if (mark_checked_reg) begin
                    cand[0] = '{line_offset: LINE_OFFSET_W'(fn.ofs), offset_kind: KIND_BREAK,
                                encoding_used: active_enc_reg, last_of_run: 1'b0};
                    cv[0]          = fn.emit;
                    prev_char_next = fn.prev;
                    pend_next      = fn.pend;
                    phase_next     = fn.phase;
                end else if (held_count_reg == 2'd2) begin
                    mark_checked_next = 1'b1;
                    held_count_next   = 2'd3;
                    active_enc_next   = mark_enc;
                    cand[0].offset_kind   = KIND_FIRST;
                    cand[0].encoding_used = mark_enc;
                    cand[0].line_offset   = skip0 ? LINE_OFFSET_W'(0) :
                                            mark_wide ? LINE_OFFSET_W'(2) : LINE_OFFSET_W'(3);
                    cv[0] = 1'b1;
                    cand[1] = '{line_offset: LINE_OFFSET_W'(f1.ofs), offset_kind: KIND_BREAK,
                                encoding_used: mark_enc, last_of_run: 1'b0};
                    cv[1]   = skip0 && f1.emit;
                    cand[2] = '{line_offset: LINE_OFFSET_W'(f2.ofs), offset_kind: KIND_BREAK,
                                encoding_used: mark_enc, last_of_run: 1'b0};
                    cv[2]   = skip0 && f2.emit;
                    if (skip0) begin
                        prev_char_next = f2.prev;
                        pend_next      = f2.pend;
                        phase_next     = f2.phase;
                    end else if (mark_wide) begin
                        prev_char_next = fm.prev;
                        pend_next      = fm.pend;
                        phase_next     = fm.phase;
                    end else begin
                        prev_char_next = '0;
                        phase_next     = 1'b0;
                    end
                end else begin
                    held_next[held_count_reg[0]] = s_data_byte;
                    held_count_next = held_count_reg + 2'd1;
                end
            end
        end

        // the last valid candidate closes the run
        cand[2].last_of_run = cv[2];
        cand[1].last_of_run = cv[1] && !cv[2];
        cand[0].last_of_run = cv[0] && !cv[1] && !cv[2];
    end

    // pack the candidates and push them behind the current queue contents
    always_comb begin
        logic [1:0] p;
        logic [2:0] base;
        logic [2:0] idx;
        p = 2'd0;
        for (int k = 0; k < 3; k++) begin
            pk[k] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            if (cv[k]) begin
                pk[p] = cand[k];
                p     = p + 2'd1;
            end
        end
        npush = p;

        q_next = q_reg;
        if (pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                q_next[i] = q_reg[i+1];
            end
        end
        base = count_reg - {2'b00, pop};
        for (int k = 0; k < 3; k++) begin
            idx = base + 3'(k);
            if (k < int'(npush)) begin
                q_next[idx[1:0]] = pk[k];
            end
        end
        count_next = base + {1'b0, npush};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_enc_reg  <= ENC_BYTES;
            byte_count_reg   <= '0;
            prev_char_reg    <= '0;
            held_count_reg   <= '0;
            mark_checked_reg <= 1'b0;
            active_enc_reg   <= ENC_BYTES;
            pend_reg         <= '0;
            phase_reg        <= 1'b0;
            count_reg        <= '0;
        end else begin
            default_enc_reg  <= default_enc_next;
            byte_count_reg   <= byte_count_next;
            prev_char_reg    <= prev_char_next;
            held_count_reg   <= held_count_next;
            mark_checked_reg <= mark_checked_next;
            active_enc_reg   <= active_enc_next;
            pend_reg         <= pend_next;
            phase_reg        <= phase_next;
            count_reg        <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        q_reg    <= q_next;
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_checked_full: assert property (@(posedge aclk) disable iff (!aresetn)
        mark_checked_reg |-> held_count_reg == 2'd3)
        else $error("mark checked without three bytes held");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_end_marker |=> m_valid && !mark_checked_reg && byte_count_reg == '0)
        else $error("end of file did not emit or clear state");

    a_phase_wide: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (active_enc_reg == ENC_LE || active_enc_reg == ENC_BE))
        else $error("half pair pending in byte mode");

    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= 3'd2 |-> !s_ready)
        else $error("item accepted without room for its results");

endmodule
